@@ rtl/core/tnr_pkg.sv @@
package tnr_pkg;

    // Frame store and word geometry.
    localparam int MAX_FRAME_WORDS_DEF = 262144;
    localparam int WORD_W              = 32;
    localparam int LANE_W              = 8;
    localparam int LANES               = WORD_W / LANE_W;
    localparam int THR_W               = 9;

    // Queue depths between the front, the back and the result side.
    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 4;

    // Configuration port geometry and register indexes.
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = REG_IDX_W'(0);

    // Fixed-point reciprocal of three (one third in Q16).
    localparam logic [14:0] THIRD_MUL = 15'd21845;

    // Lower band edge: half the threshold plus one, or zero when filtering is off.
    function automatic logic [THR_W-1:0] thr_low(input logic [THR_W-1:0] thr);
        logic [THR_W-1:0] t1;
        if (thr == '0)
        begin
            t1 = '0;
        end
        else
        begin
            t1 = {1'b0, thr[THR_W-1:1]} + THR_W'(1);
        end
        return t1;
    endfunction

    // Three-band filter of one 8-bit sample against its previous value.
    function automatic logic [LANE_W-1:0] filter_lane(
        input logic [LANE_W-1:0] p,
        input logic [LANE_W-1:0] c,
        input logic [THR_W-1:0]  t1,
        input logic [THR_W-1:0]  t2
    );
        logic [THR_W-1:0]  d;
        logic [9:0]        blend;
        logic [9:0]        mix;
        logic [24:0]       prod;
        logic [LANE_W-1:0] r;
        d     = (p > c) ? {1'b0, p - c} : {1'b0, c - p};
        blend = {2'b00, p} + {1'b0, p, 1'b0} + {2'b00, c} + 10'd2;
        mix   = {1'b0, c, 1'b0} + {2'b00, p};
        prod  = 25'(mix) * 25'(THIRD_MUL);
        if (d <= t1)
        begin
            r = blend[9:2];
        end
        else if (d <= t2)
        begin
            r = prod[23:16];
        end
        else
        begin
            r = c;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/tnr_queue.sv @@
module tnr_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic [WIDTH-1:0]               wdata,
    output logic                           full,
    input  logic                           pop,
    output logic [WIDTH-1:0]               rdata,
    output logic                           empty,
    output logic [$clog2(DEPTH+1)-1:0]     count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push_ok;
    logic             pop_ok;

    // Status and read side.
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = slots_reg[rd_ptr_reg];
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop_ok)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push_ok && !pop_ok)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop_ok && !push_ok)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Entry storage; no reset needed on payload.
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            slots_reg[wr_ptr_reg] <= wdata;
        end
    end

    // The fill count must agree with the distance between the pointers.
    a_count_matches_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0 && count_reg != CNT_W'(DEPTH)) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue count disagrees with pointers");

endmodule

@@ rtl/core/tnr_front.sv @@
module tnr_front #(
    parameter int MAX_FRAME_WORDS = tnr_pkg::MAX_FRAME_WORDS_DEF,
    parameter int ADDR_W          = (MAX_FRAME_WORDS > 1) ? $clog2(MAX_FRAME_WORDS) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              frame_start,
    output logic [ADDR_W-1:0] addr,
    output logic              fresh
);

    localparam int HWM_W = $clog2(MAX_FRAME_WORDS + 1);
    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(MAX_FRAME_WORDS - 1);

    logic [ADDR_W-1:0] pos_reg;
    logic [HWM_W-1:0]  hwm_reg;

    // Store position of this beat; a frame start restarts at zero.
    assign addr = frame_start ? '0 : pos_reg;

    // Positions only step by one or restart at zero, so the written entries
    // always form a prefix of the store. A beat at the high-water mark reads
    // an entry never written since reset, which counts as zero.
    assign fresh = (HWM_W'(addr) == hwm_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            hwm_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= (addr == LAST) ? '0 : addr + ADDR_W'(1);
            if (fresh)
            begin
                hwm_reg <= hwm_reg + HWM_W'(1);
            end
        end
    end

    // The high-water mark never passes the end of the store.
    a_hwm_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        hwm_reg <= HWM_W'(MAX_FRAME_WORDS))
        else $error("high-water mark beyond store");

    // A position is never beyond the high-water mark.
    a_addr_in_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (HWM_W'(addr) <= hwm_reg))
        else $error("position skipped past high-water mark");

endmodule

@@ rtl/core/tnr_back.sv @@
module tnr_back #(
    parameter int MAX_FRAME_WORDS = tnr_pkg::MAX_FRAME_WORDS_DEF,
    parameter int ADDR_W          = (MAX_FRAME_WORDS > 1) ? $clog2(MAX_FRAME_WORDS) : 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            mq_empty,
    input  logic [tnr_pkg::WORD_W-1:0]      mq_pixel,
    input  logic [ADDR_W-1:0]               mq_addr,
    input  logic                            mq_fresh,
    output logic                            mq_pop,
    input  logic [tnr_pkg::THR_W-1:0]       threshold,
    output logic                            empty,
    input  logic                            pop,
    output logic [tnr_pkg::WORD_W-1:0]      filtered_word
);

    localparam int CNT_W = $clog2(tnr_pkg::OUT_DEPTH + 1);
    localparam int OCC_W = CNT_W + 1;

    logic [tnr_pkg::WORD_W-1:0] frame_mem [MAX_FRAME_WORDS];
    logic [tnr_pkg::WORD_W-1:0] rd_data_reg;
    logic                       b1_valid_reg;
    logic [tnr_pkg::WORD_W-1:0] b1_pixel_reg;
    logic [ADDR_W-1:0]          b1_addr_reg;
    logic                       b1_fresh_reg;
    logic                       fwd_reg;
    logic [tnr_pkg::WORD_W-1:0] fwd_data_reg;
    logic [tnr_pkg::WORD_W-1:0] prev;
    logic [tnr_pkg::WORD_W-1:0] res;
    logic [tnr_pkg::THR_W-1:0]  t1;
    logic [CNT_W-1:0]           oq_count;
    logic                       oq_full;
    logic [OCC_W-1:0]           occ;
    logic                       take;
    logic                       collide;

    // Draw a beat only when the result queue is sure to have room for it.
    assign occ     = OCC_W'(oq_count) + OCC_W'(b1_valid_reg);
    assign take    = !mq_empty && (occ < OCC_W'(tnr_pkg::OUT_DEPTH));
    assign mq_pop  = take;

    // The beat in the filter stage writes the entry that the drawn beat reads.
    assign collide = b1_valid_reg && (b1_addr_reg == mq_addr);

    // Frame store: one read and one write a cycle, registered read data.
    always_ff @(posedge clk)
    begin
        if (b1_valid_reg)
        begin
            frame_mem[b1_addr_reg] <= res;
        end
        if (take)
        begin
            rd_data_reg <= frame_mem[mq_addr];
        end
    end

    // Filter stage payload and forwarding of the word being written.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            b1_pixel_reg <= mq_pixel;
            b1_addr_reg  <= mq_addr;
            b1_fresh_reg <= mq_fresh;
            fwd_reg      <= collide;
            fwd_data_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= take;
        end
    end

    // Previous word: forwarded, never written (zero), or from the store.
    assign prev = fwd_reg ? fwd_data_reg : (b1_fresh_reg ? '0 : rd_data_reg);
    assign t1   = tnr_pkg::thr_low(threshold);

    // Four independent lanes.
    always_comb
    begin
        for (int i = 0; i < tnr_pkg::LANES; i++)
        begin
            res[i*tnr_pkg::LANE_W +: tnr_pkg::LANE_W] = tnr_pkg::filter_lane(
                prev[i*tnr_pkg::LANE_W +: tnr_pkg::LANE_W],
                b1_pixel_reg[i*tnr_pkg::LANE_W +: tnr_pkg::LANE_W],
                t1, threshold);
        end
    end

    // Result queue towards the consumer.
    tnr_queue #(
        .WIDTH (tnr_pkg::WORD_W),
        .DEPTH (tnr_pkg::OUT_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (b1_valid_reg),
        .wdata (res),
        .full  (oq_full),
        .pop   (pop),
        .rdata (filtered_word),
        .empty (empty),
        .count (oq_count)
    );

    // The room check must keep every filtered beat from meeting a full queue.
    a_no_result_drop: assert property (@(posedge clk) disable iff (!rst_n)
        b1_valid_reg |-> !oq_full)
        else $error("filtered beat met a full result queue");

endmodule

@@ rtl/core/temporal_noise_reduction_unit.sv @@
// Channel   Dir  Handshake                        Beat contents
// input     in   push / full                      pixel_word[31:0], frame_start
// result    out  pop / empty                      filtered_word[31:0]
// config    in   psel, penable, pwrite (APB)      threshold[8:0] at byte address 0
//
// Sustained rate is one word a clock while the consumer keeps popping; the frame
// store's single read port and single write port each serve one word a cycle.
// An accepted word moves through front queue, filter stage and result queue.
// Reset needs no clearing pass: a high-water mark over store positions makes
// entries not yet written read as zero, so words are accepted right away.
// full rises when the two-entry front queue is full; the back draws from it
// only while the four-entry result queue has room, so pop stalls propagate.
module temporal_noise_reduction_unit #(
    parameter int MAX_FRAME_WORDS = tnr_pkg::MAX_FRAME_WORDS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [tnr_pkg::WORD_W-1:0]      pixel_word,
    input  logic                            frame_start,
    output logic                            empty,
    input  logic                            pop,
    output logic [tnr_pkg::WORD_W-1:0]      filtered_word,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tnr_pkg::PADDR_W-1:0]     paddr,
    input  logic [tnr_pkg::PDATA_W-1:0]     pwdata,
    output logic [tnr_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);

    localparam int ADDR_W = (MAX_FRAME_WORDS > 1) ? $clog2(MAX_FRAME_WORDS) : 1;
    localparam int MQ_W   = tnr_pkg::WORD_W + ADDR_W + 1;

    logic [tnr_pkg::THR_W-1:0]     thr_reg;
    logic [tnr_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          cfg_wr;
    logic                          accept;
    logic [ADDR_W-1:0]             fr_addr;
    logic                          fr_fresh;
    logic [MQ_W-1:0]               mq_wdata;
    logic [MQ_W-1:0]               mq_rdata;
    logic                          mq_empty;
    logic                          mq_pop;

    // Configuration port.
    assign pready  = 1'b1;
    assign reg_idx = paddr[tnr_pkg::PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_wr && (reg_idx == tnr_pkg::REG_THRESHOLD))
        begin
            thr_reg <= pwdata[tnr_pkg::THR_W-1:0];
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            tnr_pkg::REG_THRESHOLD: prdata = tnr_pkg::PDATA_W'(thr_reg);
            default:                prdata = '0;
        endcase
    end

    // Front: store position and whether the entry was ever written.
    assign accept = push && !full;

    tnr_front #(
        .MAX_FRAME_WORDS (MAX_FRAME_WORDS),
        .ADDR_W          (ADDR_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .frame_start (frame_start),
        .addr        (fr_addr),
        .fresh       (fr_fresh)
    );

    // Short queue between front and back.
    assign mq_wdata = {pixel_word, fr_addr, fr_fresh};

    tnr_queue #(
        .WIDTH (MQ_W),
        .DEPTH (tnr_pkg::MID_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (mq_wdata),
        .full  (full),
        .pop   (mq_pop),
        .rdata (mq_rdata),
        .empty (mq_empty),
        .count ()
    );

    // Back: frame store, lane filters and result queue.
    tnr_back #(
        .MAX_FRAME_WORDS (MAX_FRAME_WORDS),
        .ADDR_W          (ADDR_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .mq_empty      (mq_empty),
        .mq_pixel      (mq_rdata[MQ_W-1 -: tnr_pkg::WORD_W]),
        .mq_addr       (mq_rdata[ADDR_W:1]),
        .mq_fresh      (mq_rdata[0]),
        .mq_pop        (mq_pop),
        .threshold     (thr_reg),
        .empty         (empty),
        .pop           (pop),
        .filtered_word (filtered_word)
    );

endmodule

@@ bench/tnr_checker.sv @@
`timescale 1ns / 1ps

module tnr_checker #(
    parameter int FRAME_WORDS = tnr_pkg::MAX_FRAME_WORDS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic                        full,
    input  logic [tnr_pkg::WORD_W-1:0]  pixel_word,
    input  logic                        frame_start,
    input  logic                        empty,
    input  logic                        pop,
    input  logic [tnr_pkg::WORD_W-1:0]  filtered_word,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [tnr_pkg::PADDR_W-1:0] paddr,
    input  logic [tnr_pkg::PDATA_W-1:0] pwdata,
    output int                          fail_count,
    output int                          outstanding
);

    // One third in Q16, used for the middle band.
    localparam int unsigned THIRD_Q16 = 21845;

    logic [tnr_pkg::THR_W-1:0]  threshold;
    int unsigned                word_pos;
    logic [tnr_pkg::WORD_W-1:0] frame_history [int unsigned];
    logic [tnr_pkg::WORD_W-1:0] expected_filtered [$];

    // Filters one sample against the same lane of the previous frame.
    function automatic logic [tnr_pkg::LANE_W-1:0] denoise_sample(
        input logic [tnr_pkg::LANE_W-1:0] p,
        input logic [tnr_pkg::LANE_W-1:0] c,
        input logic [tnr_pkg::THR_W-1:0]  lo,
        input logic [tnr_pkg::THR_W-1:0]  hi
    );
        int unsigned pv;
        int unsigned cv;
        int unsigned diff;
        int unsigned r;
        pv   = p;
        cv   = c;
        diff = (pv > cv) ? pv - cv : cv - pv;
        if (diff <= lo)
        begin
            r = (3 * pv + cv + 2) >> 2;
        end
        else if (diff <= hi)
        begin
            r = ((2 * cv + pv) * THIRD_Q16) >> 16;
        end
        else
        begin
            r = cv;
        end
        if (r > 255)
        begin
            r = 255;
        end
        return r[tnr_pkg::LANE_W-1:0];
    endfunction

    // Filters a whole word lane by lane with the band edges of the threshold.
    function automatic logic [tnr_pkg::WORD_W-1:0] denoise_word(
        input logic [tnr_pkg::WORD_W-1:0] prev,
        input logic [tnr_pkg::WORD_W-1:0] cur,
        input logic [tnr_pkg::THR_W-1:0]  thr
    );
        logic [tnr_pkg::THR_W-1:0]  lo;
        logic [tnr_pkg::WORD_W-1:0] w;
        lo = (thr == '0) ? '0 : (thr >> 1) + tnr_pkg::THR_W'(1);
        for (int lane = 0; lane < tnr_pkg::LANES; lane++)
        begin
            w[lane*tnr_pkg::LANE_W +: tnr_pkg::LANE_W] = denoise_sample(
                prev[lane*tnr_pkg::LANE_W +: tnr_pkg::LANE_W],
                cur[lane*tnr_pkg::LANE_W +: tnr_pkg::LANE_W], lo, thr);
        end
        return w;
    endfunction

    // Watches the three channels at each rising edge, predicts and compares.
    always @(posedge clk or negedge rst_n)
    begin
        logic [tnr_pkg::WORD_W-1:0] prev;
        logic [tnr_pkg::WORD_W-1:0] res;
        logic [tnr_pkg::WORD_W-1:0] want;
        if (!rst_n)
        begin
            threshold  = '0;
            word_pos   = 0;
            frame_history.delete();
            expected_filtered.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            // Register writes; addresses other than the threshold are ignored.
            if (psel && penable && pwrite && pready
                && paddr[tnr_pkg::PADDR_W-1:2] == tnr_pkg::REG_THRESHOLD)
            begin
                threshold = pwdata[tnr_pkg::THR_W-1:0];
            end

            // Accepted input beat: update the model store and queue the result.
            if (push && !full)
            begin
                if (frame_start || word_pos >= FRAME_WORDS)
                begin
                    word_pos = 0;
                end
                prev = frame_history.exists(word_pos) ? frame_history[word_pos] : '0;
                res  = denoise_word(prev, pixel_word, threshold);
                frame_history[word_pos] = res;
                word_pos = (word_pos + 1 >= FRAME_WORDS) ? 0 : word_pos + 1;
                expected_filtered.insert(expected_filtered.size(), res);
            end

            // Accepted result beat: compare with the oldest expectation.
            if (pop && !empty)
            begin
                if (expected_filtered.size() == 0)
                begin
                    $error("filtered_word: unexpected result, expected none, actual %h",
                           filtered_word);
                    fail_count++;
                end
                else
                begin
                    want = expected_filtered.pop_front();
                    if (filtered_word !== want)
                    begin
                        $error("filtered_word mismatch: expected %h, actual %h",
                               want, filtered_word);
                        fail_count++;
                    end
                end
            end
            outstanding = expected_filtered.size();
        end
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

    // A small store lets the position wrap many times within the run.
    localparam int FRAME_WORDS  = 40;
    localparam int PHASE_WORDS  = 200;
    localparam int LIMIT_CYCLES = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [tnr_pkg::PADDR_W-1:0] ADDR_THRESHOLD = {tnr_pkg::REG_THRESHOLD, 2'b00};
    localparam logic [tnr_pkg::PADDR_W-1:0] ADDR_UNMAPPED  = {~tnr_pkg::REG_THRESHOLD, 2'b00};

    logic                        clk         = 1'b0;
    logic                        rst_n       = 1'b0;
    logic                        push        = 1'b0;
    logic                        full;
    logic [tnr_pkg::WORD_W-1:0]  pixel_word  = '0;
    logic                        frame_start = 1'b0;
    logic                        empty;
    logic                        pop         = 1'b0;
    logic [tnr_pkg::WORD_W-1:0]  filtered_word;
    logic                        psel        = 1'b0;
    logic                        penable     = 1'b0;
    logic                        pwrite      = 1'b0;
    logic [tnr_pkg::PADDR_W-1:0] paddr       = '0;
    logic [tnr_pkg::PDATA_W-1:0] pwdata      = '0;
    logic [tnr_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    int          fail_count;
    int          outstanding;
    int          send_idle   = 11;
    int          recv_idle   = 48;
    int unsigned cycle_count = 0;
    int unsigned send_pos    = 0;
    logic [tnr_pkg::WORD_W-1:0] last_sent [FRAME_WORDS];

    temporal_noise_reduction_unit #(
        .MAX_FRAME_WORDS(FRAME_WORDS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .pixel_word   (pixel_word),
        .frame_start  (frame_start),
        .empty        (empty),
        .pop          (pop),
        .filtered_word(filtered_word),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    tnr_checker #(
        .FRAME_WORDS(FRAME_WORDS)
    ) denoise_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .pixel_word   (pixel_word),
        .frame_start  (frame_start),
        .empty        (empty),
        .pop          (pop),
        .filtered_word(filtered_word),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The receiver stalls at random according to the current idling rate.
    always @(posedge clk)
    begin
        pop <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Guard against a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offers one input beat after a random gap and waits until it is taken.
    task automatic send_word(input logic [tnr_pkg::WORD_W-1:0] w, input logic fs);
        while ($urandom_range(0, 99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        pixel_word  <= w;
        frame_start <= fs;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        if (fs)
        begin
            send_pos = 0;
        end
        last_sent[send_pos] = w;
        send_pos = (send_pos + 1) % FRAME_WORDS;
    endtask

    // Holds the sender off until every expected result has been taken.
    task automatic drain();
        push <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (outstanding != 0);
        @(posedge clk);
    endtask

    // Register write: setup, then access held until pready.
    task automatic write_reg(input logic [tnr_pkg::PADDR_W-1:0] addr,
                             input logic [tnr_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes a threshold with random junk in the bits above it.
    task automatic set_threshold(input logic [tnr_pkg::THR_W-1:0] thr);
        logic [tnr_pkg::PDATA_W-1:0] junk;
        junk = $urandom();
        write_reg(ADDR_THRESHOLD, {junk[tnr_pkg::PDATA_W-1:tnr_pkg::THR_W], thr});
    endtask

    // A word whose lanes lie within a spread of a base word.
    function automatic logic [tnr_pkg::WORD_W-1:0] nearby_word(
        input logic [tnr_pkg::WORD_W-1:0] base,
        input int                         spread
    );
        logic [tnr_pkg::WORD_W-1:0] w;
        int v;
        for (int lane = 0; lane < tnr_pkg::LANES; lane++)
        begin
            v = int'(base[lane*tnr_pkg::LANE_W +: tnr_pkg::LANE_W])
                + int'($urandom_range(0, 2 * spread)) - spread;
            v = (v < 0) ? 0 : (v > 255) ? 255 : v;
            w[lane*tnr_pkg::LANE_W +: tnr_pkg::LANE_W] = v[tnr_pkg::LANE_W-1:0];
        end
        return w;
    endfunction

    // Whole frames of varying length, mostly close to the previous frame,
    // with some unrelated words and stray frame starts mixed in.
    task automatic random_frames(input int count);
        int sent;
        int len;
        int pick;
        int spread;
        logic [tnr_pkg::WORD_W-1:0] w;
        sent = 0;
        while (sent < count)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(FRAME_WORDS, FRAME_WORDS + 10)
                                              : $urandom_range(1, FRAME_WORDS);
            for (int i = 0; i < len && sent < count; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 6)
                begin
                    send_word($urandom(), 1'($urandom_range(0, 1)));
                end
                else
                begin
                    spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4)
                                                         : $urandom_range(5, 60);
                    w = (pick < 70) ? nearby_word(last_sent[(i == 0) ? 0 : send_pos], spread)
                                    : $urandom();
                    send_word(w, i == 0);
                end
                sent++;
            end
        end
    endtask

    // One idling phase: two halves under different thresholds.
    task automatic run_phase(input logic [tnr_pkg::THR_W-1:0] thr_a,
                             input logic [tnr_pkg::THR_W-1:0] thr_b);
        drain();
        set_threshold(thr_a);
        random_frames(PHASE_WORDS / 2);
        drain();
        set_threshold(thr_b);
        random_frames(PHASE_WORDS - PHASE_WORDS / 2);
    endtask

    initial
    begin
        for (int i = 0; i < FRAME_WORDS; i++)
        begin
            last_sent[i] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Threshold zero after reset: every lane passes straight through.
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h807F_01FE, 1'b0);

        // A write to an unmapped address must leave the threshold at zero.
        drain();
        write_reg(ADDR_UNMAPPED, 32'h0000_0014);
        send_word(32'hFAFB_FCFD, 1'b1);

        // Threshold 20 with high junk bits: band edges at 11 and 20.
        drain();
        write_reg(ADDR_THRESHOLD, 32'hFFFF_FE14);
        send_word(32'hFFF0_E800, 1'b1);
        send_word(32'h0C15_FF00, 1'b0);
        send_word(32'h00FF_FE01, 1'b0);

        // Largest threshold: every difference falls in the strong blend.
        drain();
        write_reg(ADDR_THRESHOLD, 32'hFFFF_FFFF);
        send_word(32'h00FF_00FF, 1'b1);
        send_word(32'hFF00_FF00, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);

        // Smallest thresholds, where the middle band is empty or one wide.
        drain();
        set_threshold(9'd1);
        send_word(32'h4040_4040, 1'b1);
        send_word(32'h4142_4340, 1'b1);
        drain();
        set_threshold(9'd2);
        send_word(32'h4344_3F3C, 1'b1);
        send_word(32'h4146_4040, 1'b1);
        drain();
        set_threshold(9'd3);
        send_word(32'h4449_3D40, 1'b1);
        send_word(32'h4040_4040, 1'b1);

        // Random frames under the three idling regimes.
        run_phase(tnr_pkg::THR_W'($urandom_range(8, 120)), 9'd511);
        send_idle = 48;
        recv_idle = 11;
        run_phase(9'd0, tnr_pkg::THR_W'($urandom_range(1, 510)));
        send_idle = 0;
        recv_idle = 0;
        run_phase(tnr_pkg::THR_W'($urandom_range(2, 64)),
                  tnr_pkg::THR_W'($urandom_range(100, 300)));

        // Wait for the last results, then let the pipeline settle.
        push <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ temporal_noise_reduction_unit.f @@
rtl/core/tnr_pkg.sv
rtl/core/tnr_queue.sv
rtl/core/tnr_front.sv
rtl/core/tnr_back.sv
rtl/core/temporal_noise_reduction_unit.sv
bench/tnr_checker.sv
bench/tb.sv
